[src/frks_pkg.sv]
// Shared constants, types and command bundle for the FIFO replacement key set.
`default_nettype none
package frks_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int KEY_BITS  = 32;
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = 5;
    localparam int AGE_W     = 4;
    localparam int DIFF_W    = CNT_W + 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic clear;
    } t_ctrl_cmd;

endpackage
`default_nettype wire

[src/frks_ctrl.sv]
// Controller state machine: sequences the load and execute steps of each word.
`default_nettype none
module frks_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic              i_cfg_we,
    output frks_pkg::t_ctrl_cmd    o_cmd
);

    frks_pkg::t_state r_state;
    frks_pkg::t_state n_state;

    always_comb begin
        unique case (r_state)
            frks_pkg::S_IDLE: n_state = i_accept ? frks_pkg::S_EXEC : frks_pkg::S_IDLE;
            frks_pkg::S_EXEC: n_state = i_accept ? frks_pkg::S_EXEC : frks_pkg::S_IDLE;
            default:          n_state = frks_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frks_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.load  = i_accept;
    assign o_cmd.exec  = (r_state == frks_pkg::S_EXEC);
    assign o_cmd.clear = i_cfg_we;

endmodule
`default_nettype wire

[src/frks_dp.sv]
// Datapath: slot store with parallel compare, FIFO head, fill count and result registers.
`default_nettype none
module frks_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire frks_pkg::t_ctrl_cmd            i_cmd,
    input  wire logic [frks_pkg::CNT_W-1:0]     i_cfg_wdata,
    input  wire logic                           i_req_type,
    input  wire logic [frks_pkg::KEY_BITS-1:0]  i_key,
    input  wire logic [frks_pkg::AGE_W-1:0]     i_age_position,
    output logic                                o_strobe,
    output logic                                o_hit,
    output logic                                o_evicted_valid,
    output logic [frks_pkg::KEY_BITS-1:0]       o_evicted_key,
    output logic [frks_pkg::CNT_W-1:0]          o_occupancy,
    output logic                                o_read_valid,
    output logic [frks_pkg::KEY_BITS-1:0]       o_read_key
);

    // Captured word
    logic                           r_req;
    logic [frks_pkg::KEY_BITS-1:0]  r_key;
    logic [frks_pkg::AGE_W-1:0]     r_age;

    // Store state
    logic [frks_pkg::KEY_BITS-1:0]  r_slot_key [frks_pkg::MAX_SLOTS];
    logic [frks_pkg::MAX_SLOTS-1:0] r_slot_valid;
    logic [frks_pkg::SLOT_W-1:0]    r_head;
    logic [frks_pkg::CNT_W-1:0]     r_count;
    logic [frks_pkg::CNT_W-1:0]     r_cap;

    // Result registers
    logic                           r_strobe;
    logic                           r_hit;
    logic                           r_ev_valid;
    logic [frks_pkg::KEY_BITS-1:0]  r_ev_key;
    logic [frks_pkg::CNT_W-1:0]     r_occ;
    logic                           r_rd_valid;
    logic [frks_pkg::KEY_BITS-1:0]  r_rd_key;

    logic [frks_pkg::MAX_SLOTS-1:0] match_vec;
    logic                           match;
    logic                           full;
    logic                           evict;
    logic                           insert;
    logic [frks_pkg::DIFF_W-1:0]    diff;
    logic [frks_pkg::DIFF_W-1:0]    wrapped;
    logic [frks_pkg::SLOT_W-1:0]    age_idx;
    logic [frks_pkg::SLOT_W-1:0]    rd_addr;
    logic [frks_pkg::KEY_BITS-1:0]  rd_data;
    logic                           age_ok;
    logic [frks_pkg::SLOT_W-1:0]    n_head;
    logic [frks_pkg::CNT_W-1:0]     n_count;
    logic [frks_pkg::CNT_W-1:0]     cap_eff;

    always_comb begin
        for (int i = 0; i < frks_pkg::MAX_SLOTS; i++) begin
            match_vec[i] = r_slot_valid[i] && (r_slot_key[i] == r_key);
        end
    end

    assign match  = |match_vec;
    assign full   = (r_count == r_cap);
    assign insert = !r_req && !match;
    assign evict  = insert && full && r_slot_valid[r_head];

    // Age 0 sits just behind the head; wrap by adding the capacity once.
    assign diff    = frks_pkg::DIFF_W'(r_head) - frks_pkg::DIFF_W'(1)
                   - frks_pkg::DIFF_W'(r_age);
    assign wrapped = diff[frks_pkg::DIFF_W-1] ? (diff + frks_pkg::DIFF_W'(r_cap)) : diff;
    assign age_idx = wrapped[frks_pkg::SLOT_W-1:0];
    assign age_ok  = (frks_pkg::CNT_W'(r_age) < r_count);

    assign rd_addr = r_req ? age_idx : r_head;
    assign rd_data = r_slot_key[rd_addr];

    assign n_head  = ((frks_pkg::CNT_W'(r_head) + frks_pkg::CNT_W'(1)) == r_cap)
                   ? '0 : (r_head + frks_pkg::SLOT_W'(1));
    assign n_count = (insert && !full) ? (r_count + frks_pkg::CNT_W'(1)) : r_count;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            cap_eff = frks_pkg::CNT_W'(1);
        end else if (i_cfg_wdata > frks_pkg::CNT_W'(frks_pkg::MAX_SLOTS)) begin
            cap_eff = frks_pkg::CNT_W'(frks_pkg::MAX_SLOTS);
        end else begin
            cap_eff = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_key <= i_key;
            r_age <= i_age_position;
        end
        if (i_cmd.exec && insert) begin
            r_slot_key[r_head] <= r_key;
        end
        if (i_cmd.exec) begin
            r_hit      <= !r_req && match;
            r_ev_valid <= evict;
            r_ev_key   <= evict ? rd_data : '0;
            r_occ      <= n_count;
            r_rd_valid <= r_req && age_ok;
            r_rd_key   <= (r_req && age_ok) ? rd_data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_head       <= '0;
            r_count      <= '0;
            r_cap        <= frks_pkg::CNT_W'(frks_pkg::MAX_SLOTS);
            r_strobe     <= 1'b0;
        end else begin
            r_strobe <= i_cmd.exec;
            if (i_cmd.clear) begin
                r_slot_valid <= '0;
                r_head       <= '0;
                r_count      <= '0;
                r_cap        <= cap_eff;
            end else if (i_cmd.exec && insert) begin
                r_slot_valid[r_head] <= 1'b1;
                r_head               <= n_head;
                r_count              <= n_count;
            end
        end
    end

    assign o_strobe        = r_strobe;
    assign o_hit           = r_hit;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_key   = r_ev_key;
    assign o_occupancy     = r_occ;
    assign o_read_valid    = r_rd_valid;
    assign o_read_key      = r_rd_key;

endmodule
`default_nettype wire

[src/fifo_replacement_key_set_top.sv]
// Top level of the FIFO replacement key set: controller and datapath.
// A word taken is captured in the word registers, then executed into the result registers that drive the strobe.
// Throughput: one word per cycle, as the execute step of the datapath overlaps the capture of the next word.
// busy is never raised, so a new word may follow in every cycle.
// Reset (i_rst_n low, synchronous) empties the set and sets the capacity to sixteen slots.
// The receiver cannot stall: each result is valid for exactly one cycle with o_strobe.
`default_nettype none
module fifo_replacement_key_set_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Command channel: a word is taken when start is high and busy is low.
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_req_type,
    input  wire logic [frks_pkg::KEY_BITS-1:0]  i_key,
    input  wire logic [frks_pkg::AGE_W-1:0]     i_age_position,
    // Capacity register write port.
    input  wire logic                           i_cfg_we,
    input  wire logic [frks_pkg::CNT_W-1:0]     i_cfg_wdata,
    // Result channel.
    output logic                                o_strobe,
    output logic                                o_hit,
    output logic                                o_evicted_valid,
    output logic [frks_pkg::KEY_BITS-1:0]       o_evicted_key,
    output logic [frks_pkg::CNT_W-1:0]          o_occupancy,
    output logic                                o_read_valid,
    output logic [frks_pkg::KEY_BITS-1:0]       o_read_key
);

    frks_pkg::t_ctrl_cmd cmd;
    logic                accept;

    // The state that the execute step writes is ready for the next word, so
    // the block can always take a new word.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // The controller turns the handshake into load and execute commands; a
    // capacity write becomes a clear command that also empties the store.
    frks_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cfg_we (i_cfg_we),
        .o_cmd    (cmd)
    );

    // The datapath captures the word on load, then on execute compares the key
    // against every valid slot at once, inserts at the head on a miss, evicts the
    // oldest key when full, or looks up a key by its age, and registers the result.
    frks_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req_type      (i_req_type),
        .i_key           (i_key),
        .i_age_position  (i_age_position),
        .o_strobe        (o_strobe),
        .o_hit           (o_hit),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_key   (o_evicted_key),
        .o_occupancy     (o_occupancy),
        .o_read_valid    (o_read_valid),
        .o_read_key      (o_read_key)
    );

endmodule
`default_nettype wire

[src/frks_checker.sv]
// Port-level checker for the FIFO replacement key set and its bind to the top level.
`default_nettype none
module frks_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    input  wire logic                           busy,
    input  wire logic                           o_strobe,
    input  wire logic                           o_hit,
    input  wire logic                           o_evicted_valid,
    input  wire logic                           o_read_valid,
    input  wire logic [frks_pkg::CNT_W-1:0]     o_occupancy
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("no result two cycles after an accepted word");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##2 !o_strobe)
        else $error("result strobe without an accepted word");

    a_kind_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_hit || o_evicted_valid)) |-> !o_read_valid)
        else $error("offer result also reports a read");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_evicted_valid) |->
            (!o_hit && (o_occupancy != '0) &&
             (o_occupancy <= frks_pkg::CNT_W'(frks_pkg::MAX_SLOTS))))
        else $error("eviction with a hit or an impossible occupancy");

endmodule

bind fifo_replacement_key_set_top frks_checker u_frks_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_hit           (o_hit),
    .o_evicted_valid (o_evicted_valid),
    .o_read_valid    (o_read_valid),
    .o_occupancy     (o_occupancy)
);
`default_nettype wire

[bench/tb_fifo_replacement_key_set_top.sv]
// Testbench for the FIFO replacement key set: directed and random words checked by a predictor.
`default_nettype none
module tb_fifo_replacement_key_set_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Request codes carried on i_req_type.
    localparam bit REQ_OFFER = 1'b0;
    localparam bit REQ_READ  = 1'b1;

    // The slowest correct run is roughly 1400 words with a sender gap before some
    // of them, plus the drains between phases, so this is many times over.
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    // One result word as the block presents it on the strobe.
    typedef struct packed {
        logic                          hit;
        logic                          ev_valid;
        logic [frks_pkg::KEY_BITS-1:0] ev_key;
        logic [frks_pkg::CNT_W-1:0]    occ;
        logic                          rd_valid;
        logic [frks_pkg::KEY_BITS-1:0] rd_key;
    } t_outcome;

    // Every input has a known value from time zero.
    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          start          = 1'b0;
    logic                          i_req_type     = REQ_OFFER;
    logic [frks_pkg::KEY_BITS-1:0] i_key          = '0;
    logic [frks_pkg::AGE_W-1:0]    i_age_position = '0;
    logic                          i_cfg_we       = 1'b0;
    logic [frks_pkg::CNT_W-1:0]    i_cfg_wdata    = '0;

    logic                          busy;
    logic                          o_strobe;
    logic                          o_hit;
    logic                          o_evicted_valid;
    logic [frks_pkg::KEY_BITS-1:0] o_evicted_key;
    logic [frks_pkg::CNT_W-1:0]    o_occupancy;
    logic                          o_read_valid;
    logic [frks_pkg::KEY_BITS-1:0] o_read_key;

    fifo_replacement_key_set_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_key          (i_key),
        .i_age_position (i_age_position),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_hit          (o_hit),
        .o_evicted_valid(o_evicted_valid),
        .o_evicted_key  (o_evicted_key),
        .o_occupancy    (o_occupancy),
        .o_read_valid   (o_read_valid),
        .o_read_key     (o_read_key)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the key store. Slot keys start at zero here, but the
    // stimulus never reads a slot that was not written since the last clear.
    logic [frks_pkg::KEY_BITS-1:0] shadow_keys [frks_pkg::MAX_SLOTS];
    bit                            shadow_valid[frks_pkg::MAX_SLOTS];
    int unsigned                   shadow_head;
    int unsigned                   shadow_held;
    logic [frks_pkg::CNT_W-1:0]    shadow_capacity;

    // Results predicted for accepted words, oldest first.
    t_outcome    pending_outcomes[$];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    // The capacity register is five bits wide; zero behaves as one slot and
    // anything above the slot count behaves as the full slot count.
    function automatic int unsigned slots_in_use();
        if (shadow_capacity == 0)
            return 1;
        if (shadow_capacity > frks_pkg::MAX_SLOTS)
            return frks_pkg::MAX_SLOTS;
        return shadow_capacity;
    endfunction

    // Writing the capacity empties the set at its new size.
    function automatic void shadow_write_capacity(logic [frks_pkg::CNT_W-1:0] value);
        shadow_capacity = value;
        for (int i = 0; i < frks_pkg::MAX_SLOTS; i++)
            shadow_valid[i] = 1'b0;
        shadow_head = 0;
        shadow_held = 0;
    endfunction

    function automatic void shadow_reset();
        for (int i = 0; i < frks_pkg::MAX_SLOTS; i++)
            shadow_keys[i] = '0;
        shadow_write_capacity(frks_pkg::CNT_W'(frks_pkg::MAX_SLOTS));
    endfunction

    // Applies one accepted word to the shadow store and returns the result
    // the block should produce for it.
    function automatic t_outcome shadow_apply(bit req, logic [frks_pkg::KEY_BITS-1:0] key,
                                              logic [frks_pkg::AGE_W-1:0] age);
        t_outcome    res;
        int unsigned cap;
        int unsigned idx;
        bit          found;
        res   = '0;
        cap   = slots_in_use();
        found = 1'b0;
        if (shadow_head >= cap)
            shadow_head = 0;
        if (shadow_held > cap)
            shadow_held = cap;
        if (req == REQ_OFFER) begin
            // A new key is compared against every valid slot at once.
            for (int i = 0; i < cap; i++)
                if (shadow_valid[i] && shadow_keys[i] == key)
                    found = 1'b1;
            if (found) begin
                res.hit = 1'b1;
            end else begin
                // A full store gives up its oldest key, which sits at the head.
                if (shadow_held == cap && shadow_valid[shadow_head]) begin
                    res.ev_valid = 1'b1;
                    res.ev_key   = shadow_keys[shadow_head];
                end
                shadow_keys[shadow_head]  = key;
                shadow_valid[shadow_head] = 1'b1;
                shadow_head = (shadow_head + 1) % cap;
                if (shadow_held < cap)
                    shadow_held++;
            end
            res.occ = frks_pkg::CNT_W'(shadow_held);
        end else begin
            // Age 0 is the slot just behind the head; ages past the
            // occupancy return nothing.
            res.occ = frks_pkg::CNT_W'(shadow_held);
            if (age < shadow_held) begin
                idx = (shadow_head + cap - 1 - (age % cap)) % cap;
                res.rd_valid = 1'b1;
                res.rd_key   = shadow_keys[idx];
            end
        end
        return res;
    endfunction

    // Records a failure; only the first few are described in detail.
    task automatic report_failure(string what, logic [63:0] exp_val, logic [63:0] act_val);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s: expected %0h, got %0h", $realtime, what, exp_val, act_val);
    endtask

    // Result checker. Outputs are sampled at the rising edge that ends the
    // strobe cycle, before the block updates them for the next cycle.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_strobe) begin
            if (pending_outcomes.size() == 0) begin
                report_failure("result word with no word outstanding", 64'd0, 64'd1);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_hit !== want.hit)
                    report_failure("hit", want.hit, o_hit);
                if (o_evicted_valid !== want.ev_valid)
                    report_failure("evicted_valid", want.ev_valid, o_evicted_valid);
                if (o_evicted_key !== want.ev_key)
                    report_failure("evicted_key", want.ev_key, o_evicted_key);
                if (o_occupancy !== want.occ)
                    report_failure("occupancy", want.occ, o_occupancy);
                if (o_read_valid !== want.rd_valid)
                    report_failure("read_valid", want.rd_valid, o_read_valid);
                if (o_read_key !== want.rd_key)
                    report_failure("read_key", want.rd_key, o_read_key);
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Presents one command word and holds it until the block takes it. The
    // prediction is made at the accepting edge, so it follows block order.
    task automatic send_word(bit req, logic [frks_pkg::KEY_BITS-1:0] key,
                             logic [frks_pkg::AGE_W-1:0] age);
        start          <= 1'b1;
        i_req_type     <= req;
        i_key          <= key;
        i_age_position <= age;
        do @(posedge i_clk); while (busy);
        pending_outcomes.push_back(shadow_apply(req, key, age));
    endtask

    task automatic offer_key(logic [frks_pkg::KEY_BITS-1:0] key);
        send_word(REQ_OFFER, key, frks_pkg::AGE_W'($urandom));
    endtask

    task automatic read_age(logic [frks_pkg::AGE_W-1:0] age);
        send_word(REQ_READ, frks_pkg::KEY_BITS'($urandom), age);
    endtask

    // With the given chance in a hundred, leaves start low for a gap before the next word.
    task automatic sender_gap(int unsigned pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Every word produces a result, so once nothing is outstanding the block is idle.
    task automatic drain();
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Writes the capacity register while the block is idle.
    task automatic write_capacity(logic [frks_pkg::CNT_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        shadow_write_capacity(value);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= frks_pkg::CNT_W'($urandom);
    endtask

    // Reads on the empty store after reset, key extremes, a repeat offer
    // that hits, reads inside and past the occupancy.
    task automatic test_reset_and_basics();
        read_age('0);
        read_age('1);
        offer_key('0);
        offer_key('1);
        offer_key('0);
        offer_key(32'hAAAA_AAAA);
        offer_key(32'h5555_5555);
        read_age(frks_pkg::AGE_W'(0));
        read_age(frks_pkg::AGE_W'(2));
        read_age(frks_pkg::AGE_W'(3));
        read_age(frks_pkg::AGE_W'(4));
    endtask

    // Fills all sixteen slots, then pushes past full so that the oldest keys
    // leave in order; a key offered again after its eviction is not a hit.
    task automatic test_fill_and_evict();
        for (int i = 0; i < 13; i++)
            offer_key(32'h1000_0000 + i);
        read_age('1);
        offer_key(32'hDEAD_BEEF);
        offer_key('0);
        offer_key(32'h1000_0005);
        read_age('1);
        read_age(frks_pkg::AGE_W'(0));
    endtask

    // Capacity out of range in both directions, and the clear that a
    // capacity write causes.
    task automatic test_capacity_edges();
        write_capacity('0);
        offer_key(32'h0F0F_0F0F);
        offer_key(32'h0F0F_0F0F);
        offer_key(32'hF0F0_F0F0);
        read_age(frks_pkg::AGE_W'(0));
        read_age(frks_pkg::AGE_W'(1));
        write_capacity('1);
        read_age(frks_pkg::AGE_W'(0));
        offer_key(32'hF0F0_F0F0);
        for (int i = 0; i < 16; i++)
            offer_key(32'h8000_0000 | i);
        read_age('1);
        write_capacity(frks_pkg::CNT_W'(1));
        offer_key(32'h1234_5678);
        offer_key(32'h8765_4321);
        read_age(frks_pkg::AGE_W'(0));
    endtask

    // Random traffic in phases. Each phase sets a capacity and a sender
    // gap rate, then offers keys from a small pool so that hits and
    // evictions are frequent, with some fully random keys mixed in, between reads by age.
    task automatic test_random_traffic();
        logic [frks_pkg::CNT_W-1:0]    caps[12] = '{5'd2, 5'd16, 5'd0, 5'd7, 5'd31, 5'd1,
                                                    5'd4, 5'd12, 5'd17, 5'd3, 5'd9, 5'd16};
        int unsigned                   gap_pct[3] = '{0, 59, 26};
        int unsigned                   cap;
        int unsigned                   pool_size;
        int unsigned                   age_val;
        logic [frks_pkg::KEY_BITS-1:0] pool_base;
        for (int ph = 0; ph < 12; ph++) begin
            write_capacity(ph == 11 ? frks_pkg::CNT_W'($urandom) : caps[ph]);
            cap       = slots_in_use();
            pool_size = $urandom_range(1, 2 * cap + 3);
            pool_base = frks_pkg::KEY_BITS'($urandom);
            for (int n = 0; n < 110; n++) begin
                sender_gap(gap_pct[ph % 3]);
                if ($urandom_range(99) < 60) begin
                    // Multiplying by an odd constant keeps pool keys distinct.
                    if ($urandom_range(9) == 0)
                        offer_key(frks_pkg::KEY_BITS'($urandom));
                    else
                        offer_key(pool_base ^ frks_pkg::KEY_BITS'(
                                      $urandom_range(pool_size - 1) * 32'h9E37_79B1));
                end else begin
                    // Mostly ages up to the capacity, sometimes any age.
                    age_val = ($urandom_range(9) < 7) ? $urandom_range(cap)
                                                      : $urandom_range(15);
                    read_age(frks_pkg::AGE_W'(age_val > 15 ? 15 : age_val));
                end
            end
        end
    endtask

    initial begin
        shadow_reset();
        // Synchronous reset held from time zero, then released for good.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_and_basics();
        test_fill_and_evict();
        test_capacity_edges();
        test_random_traffic();

        drain();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending_outcomes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

[fifo_replacement_key_set_top.f]
src/frks_pkg.sv
src/frks_ctrl.sv
src/frks_dp.sv
src/fifo_replacement_key_set_top.sv
src/frks_checker.sv
bench/tb_fifo_replacement_key_set_top.sv
